// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define TLFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define TLFQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tlfq_pkg.sv =====
// Package of types, constants and codes for the three-level feedback queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package tlfq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int LEVELS      = 3;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int PID_W       = 8;
  localparam int VAL_W       = 16;
  localparam int CFG_IDX_W   = 8;

  localparam logic [VAL_W-1:0] TIME_MAX = 16'hFFFF;

  typedef logic [1:0] level_t;
  typedef logic [1:0] status_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [VAL_W-1:0] burst;
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] run;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] running_id;
    logic             finished;
    level_t           served_level;
    logic [VAL_W-1:0] tick_time;
  } result_t;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam status_t STAT_RAN    = 2'd0;
  localparam status_t STAT_IDLE   = 2'd1;
  localparam status_t STAT_ACCEPT = 2'd2;
  localparam status_t STAT_FULL   = 2'd3;

  localparam level_t LVL0 = 2'd0;
  localparam level_t LVL1 = 2'd1;
  localparam level_t LVL2 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DEMOTE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_DEMOTE = 8'd1;

  localparam logic [VAL_W-1:0] FIRST_DEMOTE_RST  = 16'd2;
  localparam logic [VAL_W-1:0] SECOND_DEMOTE_RST = 16'd6;

endpackage
`default_nettype wire

// ===== hdl/tlfq_if.sv =====
// Channel interfaces for items, results and register writes of the scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface tlfq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [tlfq_pkg::PID_W-1:0]   process_id;
  logic [tlfq_pkg::VAL_W-1:0]   burst_length;

  modport source (output valid, output cmd, output process_id, output burst_length,
                  input ready);
  modport sink   (input valid, input cmd, input process_id, input burst_length,
                  output ready);
endinterface

interface tlfq_out_if;
  logic                         valid;
  logic                         ready;
  tlfq_pkg::status_t            status;
  logic [tlfq_pkg::PID_W-1:0]   running_id;
  logic                         finished;
  tlfq_pkg::level_t             served_level;
  logic [tlfq_pkg::VAL_W-1:0]   tick_time;

  modport source (output valid, output status, output running_id, output finished,
                  output served_level, output tick_time, input ready);
  modport sink   (input valid, input status, input running_id, input finished,
                  input served_level, input tick_time, output ready);
endinterface

interface tlfq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlfq_pkg::CFG_IDX_W-1:0] index;
  logic [tlfq_pkg::VAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tlfq_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/three_level_feedback_queue_scheduler.sv =====
// Top level of the three-level feedback queue scheduler.
// Each item is either an arrival, stamped with the current time and put in time order
// into level 0, or a tick that dispatches the head of the highest non-empty level,
// runs it for one time unit and retires, demotes or keeps it; every item gives one
// result. The three levels are ring buffers of QUEUE_DEPTH entries each in one shared
// queue memory with a single read and a single write port, and a small sequencer
// does all work through it, so the block takes one item at a time. An arrival that
// finds the system full is refused; otherwise it is written straight into an empty
// level 0, or compared only with the tail of level 0, since nothing queued there is
// stamped later than the current time. A tick runs the process already on the CPU,
// finds every level empty, or first pops the head of the highest non-empty level;
// putting a preempted or demoted process back into its level compares it with the
// queued entries from the tail until it finds its place, and a preemption then pops
// level 0. The sorted insertion steps one entry at a time through the memory port,
// reading, comparing and shifting each, and so sets the long cases. Results wait in
// an output register, so the next item is accepted while a result is still pending.
`timescale 1ns / 1ps
`default_nettype none
module three_level_feedback_queue_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  tlfq_in_if.sink     in_ch,
  tlfq_out_if.source  out_ch,
  tlfq_cfg_if.sink    cfg_ch
);
  import tlfq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ARR, ST_DISP, ST_POP_RD, ST_POP_LD,
    ST_INS_RD, ST_INS_CMP, ST_INS_WR, ST_RUN, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    RET_ARRIVE, RET_PREEMPT, RET_DEMOTE
  } ret_t;

  state_t             state_r;
  ret_t               ret_r;
  logic [VAL_W-1:0]   first_r;
  logic [VAL_W-1:0]   second_r;
  logic [CNT_W-1:0]   cnt_r [LEVELS];
  logic [IDX_W-1:0]   head_r [LEVELS];
  entry_t             cur_e_r;
  entry_t             ins_e_r;
  logic               busy_r;
  logic               pend_arr_r;
  level_t             cur_lvl_r;
  level_t             op_lvl_r;
  logic [VAL_W-1:0]   time_r;
  logic [PID_W-1:0]   pid_r;
  logic [VAL_W-1:0]   burst_r;
  logic [CNT_W-1:0]   pos_r;
  result_t            pend_r;
  result_t            out_r;
  logic               out_valid_r;

  logic [CNT_W+1:0]   total;
  logic [VAL_W-1:0]   run_nxt;
  logic [CNT_W-1:0]   pos_m1;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic               shift;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ram_q;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] phys_addr(input level_t lvl,
                                                  input logic [IDX_W-1:0] ofs);
    logic [ADDR_W-1:0] base;
    case (lvl)
      LVL1:    base = ADDR_W'(QUEUE_DEPTH);
      LVL2:    base = ADDR_W'(2 * QUEUE_DEPTH);
      default: base = '0;
    endcase
    return base + ADDR_W'(ofs);
  endfunction

  assign ram_q  = entry_t'(ram_rdata);
  assign pos_m1 = pos_r - CNT_W'(1);
  assign shift  = ram_q.arrival > ins_e_r.arrival;

  always_comb begin
    rd_idx    = (state_r == ST_INS_RD) ? pos_m1[IDX_W-1:0] : '0;
    wr_idx    = pos_r[IDX_W-1:0];
    ram_raddr = phys_addr(op_lvl_r, wrap_idx(head_r[op_lvl_r], rd_idx));
    ram_waddr = phys_addr(op_lvl_r, wrap_idx(head_r[op_lvl_r], wr_idx));
    ram_we    = ((state_r == ST_INS_CMP) && shift) || (state_r == ST_INS_WR);
    ram_wdata = (state_r == ST_INS_WR) ? ins_e_r : ram_q;
    total     = (CNT_W+2)'(cnt_r[0]) + (CNT_W+2)'(cnt_r[1]) + (CNT_W+2)'(cnt_r[2])
              + (CNT_W+2)'(busy_r);
    run_nxt   = (cur_e_r.run != TIME_MAX) ? cur_e_r.run + VAL_W'(1) : cur_e_r.run;
  end

  tlfq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LEVELS * QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.running_id   = out_r.running_id;
  assign out_ch.finished     = out_r.finished;
  assign out_ch.served_level = out_r.served_level;
  assign out_ch.tick_time    = out_r.tick_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= RET_ARRIVE;
      first_r     <= FIRST_DEMOTE_RST;
      second_r    <= SECOND_DEMOTE_RST;
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
      end
      cur_e_r     <= '0;
      busy_r      <= 1'b0;
      pend_arr_r  <= 1'b0;
      cur_lvl_r   <= LVL0;
      op_lvl_r    <= LVL0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_FIRST_DEMOTE) begin
          first_r <= cfg_ch.data;
        end else if (cfg_ch.index == REG_SECOND_DEMOTE) begin
          second_r <= cfg_ch.data;
        end
      end

      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            pid_r   <= in_ch.process_id;
            burst_r <= in_ch.burst_length;
            pend_r  <= '{status: STAT_RAN, running_id: '0, finished: 1'b0,
                         served_level: LVL0, tick_time: time_r};
            state_r <= (in_ch.cmd == CMD_TICK) ? ST_DISP : ST_ARR;
          end
        end

        ST_ARR: begin
          if (total >= (CNT_W+2)'(QUEUE_DEPTH)) begin
            pend_r.status <= STAT_FULL;
            state_r       <= ST_FIN;
          end else begin
            ins_e_r.pid     <= pid_r;
            ins_e_r.burst   <= burst_r;
            ins_e_r.arrival <= time_r;
            ins_e_r.run     <= '0;
            op_lvl_r        <= LVL0;
            pos_r           <= cnt_r[0];
            ret_r           <= RET_ARRIVE;
            pend_arr_r      <= 1'b1;
            pend_r.status   <= STAT_ACCEPT;
            state_r         <= (cnt_r[0] == '0) ? ST_INS_WR : ST_INS_RD;
          end
        end

        ST_DISP: begin
          if (!busy_r) begin
            if (cnt_r[0] != '0) begin
              op_lvl_r <= LVL0;
              state_r  <= ST_POP_RD;
            end else if (cnt_r[1] != '0) begin
              op_lvl_r <= LVL1;
              state_r  <= ST_POP_RD;
            end else if (cnt_r[2] != '0) begin
              op_lvl_r <= LVL2;
              state_r  <= ST_POP_RD;
            end else begin
              state_r  <= ST_RUN;
            end
          end else if (pend_arr_r && (cur_lvl_r != LVL0) && (cnt_r[0] != '0)) begin
            ins_e_r  <= cur_e_r;
            op_lvl_r <= cur_lvl_r;
            pos_r    <= cnt_r[cur_lvl_r];
            ret_r    <= RET_PREEMPT;
            state_r  <= (cnt_r[cur_lvl_r] == '0) ? ST_INS_WR : ST_INS_RD;
          end else begin
            state_r <= ST_RUN;
          end
        end

        ST_POP_RD: begin
          state_r <= ST_POP_LD;
        end

        ST_POP_LD: begin
          cur_e_r          <= ram_q;
          cur_lvl_r        <= op_lvl_r;
          busy_r           <= 1'b1;
          head_r[op_lvl_r] <= wrap_idx(head_r[op_lvl_r], IDX_W'(1));
          cnt_r[op_lvl_r]  <= cnt_r[op_lvl_r] - CNT_W'(1);
          state_r          <= ST_RUN;
        end

        ST_INS_RD: begin
          state_r <= ST_INS_CMP;
        end

        ST_INS_CMP: begin
          if (shift) begin
            pos_r   <= pos_m1;
            state_r <= (pos_r == CNT_W'(1)) ? ST_INS_WR : ST_INS_RD;
          end else begin
            state_r <= ST_INS_WR;
          end
        end

        ST_INS_WR: begin
          cnt_r[op_lvl_r] <= cnt_r[op_lvl_r] + CNT_W'(1);
          case (ret_r)
            RET_PREEMPT: begin
              op_lvl_r <= LVL0;
              state_r  <= ST_POP_RD;
            end
            default: begin
              state_r <= ST_FIN;
            end
          endcase
        end

        ST_RUN: begin
          pend_arr_r <= 1'b0;
          if (time_r != TIME_MAX) begin
            time_r <= time_r + VAL_W'(1);
          end
          if (!busy_r) begin
            pend_r.status <= STAT_IDLE;
            state_r       <= ST_FIN;
          end else begin
            pend_r.status       <= STAT_RAN;
            pend_r.running_id   <= cur_e_r.pid;
            pend_r.served_level <= cur_lvl_r;
            if (run_nxt >= cur_e_r.burst) begin
              pend_r.finished <= 1'b1;
              busy_r          <= 1'b0;
              cur_e_r         <= '0;
              state_r         <= ST_FIN;
            end else if (run_nxt == first_r) begin
              ins_e_r  <= '{pid: cur_e_r.pid, burst: cur_e_r.burst,
                            arrival: cur_e_r.arrival, run: run_nxt};
              busy_r   <= 1'b0;
              op_lvl_r <= LVL1;
              pos_r    <= cnt_r[1];
              ret_r    <= RET_DEMOTE;
              state_r  <= (cnt_r[1] == '0) ? ST_INS_WR : ST_INS_RD;
            end else if (run_nxt == second_r) begin
              ins_e_r  <= '{pid: cur_e_r.pid, burst: cur_e_r.burst,
                            arrival: cur_e_r.arrival, run: run_nxt};
              busy_r   <= 1'b0;
              op_lvl_r <= LVL2;
              pos_r    <= cnt_r[2];
              ret_r    <= RET_DEMOTE;
              state_r  <= (cnt_r[2] == '0) ? ST_INS_WR : ST_INS_RD;
            end else begin
              cur_e_r.run <= run_nxt;
              state_r     <= ST_FIN;
            end
          end
        end

        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= pend_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tlfq_checker.sv =====
// Port-level assertion checker for the scheduler, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tlfq_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  tlfq_pkg::status_t          out_status,
  input  logic [tlfq_pkg::PID_W-1:0] out_running_id,
  input  logic                       out_finished,
  input  tlfq_pkg::level_t           out_served_level
);
  import tlfq_pkg::*;

  logic no_run;

  assign no_run = (out_status == STAT_IDLE) || (out_status == STAT_ACCEPT)
               || (out_status == STAT_FULL);

  `TLFQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `TLFQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "item accepted while busy")
  `TLFQ_ASSERT_SAME(a_no_run, clk, rst_n, out_valid && no_run, (out_running_id == '0) && (out_served_level == LVL0) && !out_finished, "non-run result carries run fields")
  `TLFQ_ASSERT_SAME(a_level_ok, clk, rst_n, out_valid, out_served_level != 2'd3, "served level out of range")

endmodule

bind three_level_feedback_queue_scheduler tlfq_checker u_tlfq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_running_id   (out_ch.running_id),
  .out_finished     (out_ch.finished),
  .out_served_level (out_ch.served_level)
);
`default_nettype wire

// ===== test/tb_three_level_feedback_queue_scheduler.sv =====
// Self-checking testbench for the three-level feedback queue scheduler.
`timescale 1ns / 1ps
module tb_three_level_feedback_queue_scheduler;
  import tlfq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;

  class sched_tracker;
    entry_t           lvl_q[LEVELS][$];
    entry_t           cur;
    bit               busy;
    level_t           cur_lvl;
    bit               arr_mark;
    logic [VAL_W-1:0] now_t;
    logic [VAL_W-1:0] demote1;
    logic [VAL_W-1:0] demote2;
    result_t          pending_results[$];
    int unsigned      mismatches;

    function new();
      cur      = '0;
      busy     = 1'b0;
      cur_lvl  = LVL0;
      arr_mark = 1'b0;
      now_t    = '0;
      demote1  = FIRST_DEMOTE_RST;
      demote2  = SECOND_DEMOTE_RST;
      mismatches = 0;
    endfunction

    function void enqueue_sorted(int lvl, entry_t e);
      int pos;
      pos = lvl_q[lvl].size();
      while (pos > 0 && lvl_q[lvl][pos-1].arrival > e.arrival) pos--;
      lvl_q[lvl].insert(pos, e);
    endfunction

    function void take_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      if (idx == REG_FIRST_DEMOTE) demote1 = data;
      else if (idx == REG_SECOND_DEMOTE) demote2 = data;
    endfunction

    function void take_item(logic cmd, logic [PID_W-1:0] pid, logic [VAL_W-1:0] burst);
      result_t r;
      entry_t  e;
      int      total;
      int      lvl;
      r = '0;
      r.tick_time = now_t;
      if (cmd == CMD_ARRIVE) begin
        total = lvl_q[0].size() + lvl_q[1].size() + lvl_q[2].size() + (busy ? 1 : 0);
        if (total >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          e.pid     = pid;
          e.burst   = burst;
          e.arrival = now_t;
          e.run     = '0;
          enqueue_sorted(0, e);
          arr_mark = 1'b1;
          r.status = STAT_ACCEPT;
        end
      end else begin
        if (!busy) begin
          lvl = 0;
          while (lvl < LEVELS && lvl_q[lvl].size() == 0) lvl++;
          if (lvl < LEVELS) begin
            cur     = lvl_q[lvl].pop_front();
            cur_lvl = level_t'(lvl);
            busy    = 1'b1;
          end
        end else if (arr_mark && cur_lvl != LVL0 && lvl_q[0].size() != 0) begin
          enqueue_sorted(int'(cur_lvl), cur);
          cur     = lvl_q[0].pop_front();
          cur_lvl = LVL0;
        end
        arr_mark = 1'b0;
        if (now_t != TIME_MAX) now_t = now_t + 1'b1;
        if (!busy) begin
          r.status = STAT_IDLE;
        end else begin
          if (cur.run != 16'hFFFF) cur.run = cur.run + 1'b1;
          r.status       = STAT_RAN;
          r.running_id   = cur.pid;
          r.served_level = cur_lvl;
          if (cur.run >= cur.burst) begin
            r.finished = 1'b1;
            busy = 1'b0;
            cur  = '0;
          end else if (cur.run == demote1) begin
            enqueue_sorted(1, cur);
            busy = 1'b0;
          end else if (cur.run == demote2) begin
            enqueue_sorted(2, cur);
            busy = 1'b0;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void flag(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void take_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected, status %0d", $time, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        flag("status", VAL_W'(want.status), VAL_W'(got.status));
      if (got.running_id !== want.running_id)
        flag("running_id", VAL_W'(want.running_id), VAL_W'(got.running_id));
      if (got.finished !== want.finished)
        flag("finished", VAL_W'(want.finished), VAL_W'(got.finished));
      if (got.served_level !== want.served_level)
        flag("served_level", VAL_W'(want.served_level), VAL_W'(got.served_level));
      if (got.tick_time !== want.tick_time) flag("tick_time", want.tick_time, got.tick_time);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tlfq_in_if  in_ch ();
  tlfq_out_if out_ch ();
  tlfq_cfg_if cfg_ch ();

  three_level_feedback_queue_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sched_tracker sb = new();
  bit           steady = 1'b0;
  int           hold_req = 0;
  int           quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(int pct);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return VAL_W'($urandom_range(1, 3));
    if (r < 90) return VAL_W'($urandom_range(4, 12));
    if (r < 98) return VAL_W'($urandom_range(13, 40));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status       = out_ch.status;
        got.running_id   = out_ch.running_id;
        got.finished     = out_ch.finished;
        got.served_level = out_ch.served_level;
        got.tick_time    = out_ch.tick_time;
        sb.take_result(got);
      end
      if (in_ch.valid && in_ch.ready)
        sb.take_item(in_ch.cmd, in_ch.process_id, in_ch.burst_length);
      if (cfg_ch.valid && cfg_ch.ready) sb.take_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_three_level_feedback_queue_scheduler: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall_left;
    int n;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ch.ready = 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        n = pick_gap(15);
        if (n > 0) begin
          out_ch.ready = 1'b0;
          stall_left   = n - 1;
        end else begin
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  task automatic send_item(logic cmd, logic [PID_W-1:0] pid, logic [VAL_W-1:0] burst);
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.cmd          = cmd;
    in_ch.process_id   = pid;
    in_ch.burst_length = burst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic tick(int n);
    repeat (n) send_item(CMD_TICK, PID_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      idle_for(pick_gap(35));
      if ($urandom_range(0, 99) < 70)
        send_item(CMD_TICK, PID_W'($urandom), VAL_W'($urandom));
      else
        send_item(CMD_ARRIVE, PID_W'($urandom), pick_burst());
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_thresholds(logic [VAL_W-1:0] first, logic [VAL_W-1:0] second);
    write_reg(REG_FIRST_DEMOTE, first);
    write_reg(REG_SECOND_DEMOTE, second);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_ARRIVE;
    in_ch.process_id   = '0;
    in_ch.burst_length = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty system, field extremes, zero burst, demotion and an arrival preempting level 1
    tick(1);
    send_item(CMD_ARRIVE, 8'h00, 16'd1);
    send_item(CMD_ARRIVE, 8'hFF, 16'hFFFF);
    send_item(CMD_ARRIVE, 8'hA5, 16'd0);
    send_item(CMD_ARRIVE, 8'h5A, 16'h5555);
    tick(3);
    send_item(CMD_ARRIVE, 8'h3C, 16'd10);
    tick(4);
    send_item(CMD_ARRIVE, 8'hC3, 16'd2);
    tick(4);
    send_item(CMD_ARRIVE, 8'h81, 16'd7);
    tick(3);
    drain();

    // fill the system until arrivals bounce
    set_thresholds(16'd1, 16'hFFFF);
    repeat (70) begin
      idle_for(pick_gap(35));
      send_item(CMD_ARRIVE, PID_W'($urandom), VAL_W'($urandom_range(1, 3)));
    end
    send_random(60);
    drain();

    // hold the result side off while items keep coming
    set_thresholds(16'hFFFF, 16'd1);
    hold_req = LONG_HOLD;
    steady   = 1'b1;
    send_random(16);
    steady   = 1'b0;
    send_random(80);
    drain();

    set_thresholds(16'd0, 16'd0);
    write_reg(CFG_IDX_W'(2), 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    steady = 1'b1;
    send_random(80);
    steady = 1'b0;
    drain();

    set_thresholds(16'd3, 16'd3);
    send_random(100);
    drain();

    set_thresholds(VAL_W'($urandom_range(1, 8)), VAL_W'($urandom_range(1, 12)));
    send_random(100);
    drain();

    // back to the reset thresholds with a short burst of arrivals
    set_thresholds(FIRST_DEMOTE_RST, SECOND_DEMOTE_RST);
    steady = 1'b1;
    send_item(CMD_ARRIVE, 8'h11, 16'd3);
    send_item(CMD_ARRIVE, 8'h22, 16'd1);
    send_item(CMD_ARRIVE, 8'h33, 16'd4);
    tick(10);
    steady = 1'b0;
    send_random(40);
    drain();

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_three_level_feedback_queue_scheduler: PASS");
    end else begin
      $display("tb_three_level_feedback_queue_scheduler: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tlfq_pkg.sv
hdl/tlfq_if.sv
hdl/tlfq_ram.sv
hdl/three_level_feedback_queue_scheduler.sv
hdl/tlfq_checker.sv
test/tb_three_level_feedback_queue_scheduler.sv
